FILE: src/hsv_pkg.sv
// Shared constants and types for the RGB to HSV converter.
package hsv_pkg;

  localparam int unsigned CHANNEL_BITS_DEF      = 8;
  localparam int unsigned HUE_FRACTION_BITS_DEF = 6;

  // Hue geometry in whole degrees.
  localparam int unsigned DEG_SECTOR = 60;
  localparam int unsigned DEG_TURN   = 360;

  // Which channel holds the maximum; red wins ties, then green.
  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_e;

  // Hue bookkeeping that travels beside the hue division.
  typedef struct packed {
    logic    flat;    // all channels equal, hue forced to zero
    logic    neg;     // hue offset is negative
    sector_e sector;
  } hue_side_t;

endpackage

FILE: src/hsv_prep.sv
// Front end: max/min search, sector choice and divider operand setup.
module hsv_prep #(
  parameter int unsigned CHANNEL_BITS      = 8,
  parameter int unsigned HUE_FRACTION_BITS = 6
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            vld_i,
  input  logic [CHANNEL_BITS-1:0]         red_i,
  input  logic [CHANNEL_BITS-1:0]         green_i,
  input  logic [CHANNEL_BITS-1:0]         blue_i,
  output logic                            vld_o,
  output logic [CHANNEL_BITS-1:0]         bright_o,
  output logic [2*CHANNEL_BITS-1:0]       num_sat_o,
  output logic [CHANNEL_BITS-1:0]         den_sat_o,
  output logic [CHANNEL_BITS+$clog2(hsv_pkg::DEG_SECTOR*(2**HUE_FRACTION_BITS)+1)-1:0]
                                          num_hue_o,
  output logic [CHANNEL_BITS-1:0]         den_hue_o,
  output hsv_pkg::hue_side_t              side_o
);
  import hsv_pkg::*;

  localparam int unsigned CB     = CHANNEL_BITS;
  localparam int unsigned DEG60  = DEG_SECTOR * (2 ** HUE_FRACTION_BITS);
  localparam int unsigned QW_HUE = $clog2(DEG60 + 1);
  localparam int unsigned NH_W   = CB + QW_HUE;

  // First stage: order statistics and the signed hue difference.
  logic [CB-1:0] rg_max, rg_min, hi_d, lo_d, opa, opb, mag_d;
  sector_e       sector_d;
  logic          neg_d;

  logic          vld1_q;
  logic [CB-1:0] hi1_q, delta1_q, mag1_q;
  sector_e       sector1_q;
  logic          neg1_q;

  always_comb begin
    rg_max = (red_i > green_i) ? red_i : green_i;
    rg_min = (red_i < green_i) ? red_i : green_i;
    hi_d   = (blue_i > rg_max) ? blue_i : rg_max;
    lo_d   = (blue_i < rg_min) ? blue_i : rg_min;
    if (red_i == hi_d) begin
      sector_d = SECT_RED;
    end else if (green_i == hi_d) begin
      sector_d = SECT_GREEN;
    end else begin
      sector_d = SECT_BLUE;
    end
    case (sector_d)
      SECT_RED: begin
        opa = green_i;
        opb = blue_i;
      end
      SECT_GREEN: begin
        opa = blue_i;
        opb = red_i;
      end
      SECT_BLUE: begin
        opa = red_i;
        opb = green_i;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
    neg_d = (opa < opb);
    mag_d = neg_d ? (opb - opa) : (opa - opb);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld_o  <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld_o  <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hi1_q     <= hi_d;
      delta1_q  <= hi_d - lo_d;
      mag1_q    <= mag_d;
      sector1_q <= sector_d;
      neg1_q    <= neg_d;
    end
  end

  // Second stage: constant scalings and guarded divisors.
  // A zero divisor is replaced by one; its numerator is zero then.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bright_o         <= hi1_q;
      num_sat_o        <= {delta1_q, {CB{1'b0}}} - {{CB{1'b0}}, delta1_q};
      den_sat_o        <= (hi1_q == '0) ? CB'(1) : hi1_q;
      num_hue_o        <= NH_W'(mag1_q) * NH_W'(DEG60);
      den_hue_o        <= (delta1_q == '0) ? CB'(1) : delta1_q;
      side_o.flat      <= (delta1_q == '0);
      side_o.neg       <= neg1_q;
      side_o.sector    <= sector1_q;
    end
  end

endmodule

FILE: src/hsv_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
module hsv_div #(
  parameter int unsigned NUM_W  = 16,
  parameter int unsigned DEN_W  = 8,
  parameter int unsigned Q_W    = 12,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [Q_W-1:0]    quo_o,
  output logic              rem_nz_o,
  output logic [SIDE_W-1:0] side_o
);

  // The quotient must fit Q_W bits; the caller guarantees that.
  localparam int unsigned CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic              vld_q  [Q_W];
  logic [NUM_W-1:0]  rem_q  [Q_W];
  logic [DEN_W-1:0]  den_q  [Q_W];
  logic [Q_W-1:0]    quo_q  [Q_W];
  logic [SIDE_W-1:0] side_q [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic              vld_in;
    logic [NUM_W-1:0]  rem_in;
    logic [DEN_W-1:0]  den_in;
    logic [Q_W-1:0]    quo_in;
    logic [SIDE_W-1:0] side_in;
    logic [CW-1:0]     dsh;
    logic              ge;
    logic [NUM_W-1:0]  rem_d;
    logic [Q_W-1:0]    quo_d;

    if (k == 0) begin : g_head
      assign vld_in  = vld_i;
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_body
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign side_in = side_q[k-1];
    end

    always_comb begin
      dsh   = CW'(den_in) << (Q_W - 1 - k);
      ge    = (CW'(rem_in) >= dsh);
      rem_d = ge ? NUM_W'(CW'(rem_in) - dsh) : rem_in;
      quo_d = quo_in;
      quo_d[Q_W-1-k] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        den_q[k]  <= den_in;
        quo_q[k]  <= quo_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign vld_o    = vld_q[Q_W-1];
  assign quo_o    = quo_q[Q_W-1];
  assign rem_nz_o = |rem_q[Q_W-1];
  assign side_o   = side_q[Q_W-1];

endmodule

FILE: src/hsv_finish.sv
// Output stage: hue assembly with floor correction and wrap, result register.
module hsv_finish #(
  parameter int unsigned CHANNEL_BITS      = 8,
  parameter int unsigned HUE_FRACTION_BITS = 6,
  parameter int unsigned Q_W               = 12
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   vld_i,
  input  logic [Q_W-1:0]                         q_hue_i,
  input  logic                                   rem_nz_i,
  input  hsv_pkg::hue_side_t                     side_i,
  input  logic [Q_W-1:0]                         q_sat_i,
  input  logic [CHANNEL_BITS-1:0]                bright_i,
  output logic                                   vld_o,
  output logic [$clog2(hsv_pkg::DEG_TURN*(2**HUE_FRACTION_BITS))-1:0] hue_o,
  output logic [CHANNEL_BITS-1:0]                sat_o,
  output logic [CHANNEL_BITS-1:0]                bright_o
);
  import hsv_pkg::*;

  localparam int unsigned CB     = CHANNEL_BITS;
  localparam int unsigned DEG60  = DEG_SECTOR * (2 ** HUE_FRACTION_BITS);
  localparam int unsigned DEG360 = DEG_TURN * (2 ** HUE_FRACTION_BITS);
  localparam int unsigned HUE_W  = $clog2(DEG360);
  localparam int unsigned SW     = HUE_W + 2;

  logic [SW-1:0]        up;
  logic signed [SW-1:0] offs, base, sum;
  logic [CB-1:0]        sat_d;
  logic [HUE_W-1:0]     hue_d;

  // A negative quotient floors away from zero when the remainder is nonzero.
  always_comb begin
    up   = SW'(q_hue_i) + SW'(rem_nz_i);
    offs = side_i.neg ? -up : SW'(q_hue_i);
    case (side_i.sector)
      SECT_RED:   base = '0;
      SECT_GREEN: base = SW'(2 * DEG60);
      SECT_BLUE:  base = SW'(4 * DEG60);
      default:    base = '0;
    endcase
    sum = base + offs;
    if (sum < 0) begin
      sum = sum + SW'(DEG360);
    end
    sat_d = q_sat_i[CB-1:0];
    hue_d = (side_i.flat || (sat_d == '0)) ? '0 : sum[HUE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hue_o    <= hue_d;
      sat_o    <= sat_d;
      bright_o <= bright_i;
    end
  end

endmodule

FILE: src/rgb_to_hsv_converter.sv
// Top level of the pipelined RGB to HSV pixel converter.
//
//   Channel  Direction  Transaction carries (tdata, lowest bit first)
//   s_axis   in         red, green, blue (CHANNEL_BITS each), zero padded to bytes
//   m_axis   out        hue (HUE_W), saturation, brightness, zero padded to bytes
//
// One pixel transaction is accepted per clock while the pipeline is not held.
// There are two front-end stages, one restoring-divider stage per quotient
// bit, and the output register. Q_W is the larger of CHANNEL_BITS and the
// bit count of a 60-degree hue step.
// All stages advance together on one enable, which drops only while a result
// sits in the output register and the sink is not ready; nothing moves then.
// Reset clears the valid bits only; the datapath registers carry no reset.
module rgb_to_hsv_converter #(
  parameter int unsigned CHANNEL_BITS      = hsv_pkg::CHANNEL_BITS_DEF,
  parameter int unsigned HUE_FRACTION_BITS = hsv_pkg::HUE_FRACTION_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  // Slave side.
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // Fields from bit 0: red, green, blue.
  input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0] s_axis_tdata,
  // Master side.
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // Fields from bit 0: hue, saturation, brightness.
  output logic [(($clog2(hsv_pkg::DEG_TURN*(2**HUE_FRACTION_BITS))+2*CHANNEL_BITS+7)/8)*8-1:0]
               m_axis_tdata
);
  import hsv_pkg::*;

  localparam int unsigned CB     = CHANNEL_BITS;
  localparam int unsigned DEG60  = DEG_SECTOR * (2 ** HUE_FRACTION_BITS);
  localparam int unsigned HUE_W  = $clog2(DEG_TURN * (2 ** HUE_FRACTION_BITS));
  localparam int unsigned QW_HUE = $clog2(DEG60 + 1);
  // Saturation never exceeds full scale, hue offset never exceeds 60 degrees,
  // so one quotient width covers both divisions.
  localparam int unsigned Q_W    = (QW_HUE > CB) ? QW_HUE : CB;
  localparam int unsigned NS_W   = 2 * CB;
  localparam int unsigned NH_W   = CB + QW_HUE;
  localparam int unsigned OUT_W  = ((HUE_W + 2 * CB + 7) / 8) * 8;

  logic en;

  logic              p_vld;
  logic [CB-1:0]     p_bright;
  logic [NS_W-1:0]   p_num_sat;
  logic [CB-1:0]     p_den_sat;
  logic [NH_W-1:0]   p_num_hue;
  logic [CB-1:0]     p_den_hue;
  hue_side_t         p_side;

  logic              dh_vld;
  logic [Q_W-1:0]    dh_quo;
  logic              dh_rem_nz;
  hue_side_t         dh_side;
  logic [Q_W-1:0]    ds_quo;
  logic [CB-1:0]     ds_bright;

  logic [HUE_W-1:0]  o_hue;
  logic [CB-1:0]     o_sat;
  logic [CB-1:0]     o_bright;

  // The whole pipeline holds while a result waits; otherwise it steps each
  // cycle and a new pixel may enter behind any in flight.
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  hsv_prep #(
    .CHANNEL_BITS      (CHANNEL_BITS),
    .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
  ) u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .vld_i     (s_axis_tvalid),
    .red_i     (s_axis_tdata[0 +: CB]),
    .green_i   (s_axis_tdata[CB +: CB]),
    .blue_i    (s_axis_tdata[2*CB +: CB]),
    .vld_o     (p_vld),
    .bright_o  (p_bright),
    .num_sat_o (p_num_sat),
    .den_sat_o (p_den_sat),
    .num_hue_o (p_num_hue),
    .den_hue_o (p_den_hue),
    .side_o    (p_side)
  );

  // Hue offset: floor(60 degrees * |diff| / delta), remainder kept for flooring.
  hsv_div #(
    .NUM_W  (NH_W),
    .DEN_W  (CB),
    .Q_W    (Q_W),
    .SIDE_W ($bits(hue_side_t))
  ) u_div_hue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (p_vld),
    .num_i    (p_num_hue),
    .den_i    (p_den_hue),
    .side_i   (p_side),
    .vld_o    (dh_vld),
    .quo_o    (dh_quo),
    .rem_nz_o (dh_rem_nz),
    .side_o   (dh_side)
  );

  // Saturation: floor(full scale * delta / max); brightness rides along.
  hsv_div #(
    .NUM_W  (NS_W),
    .DEN_W  (CB),
    .Q_W    (Q_W),
    .SIDE_W (CB)
  ) u_div_sat (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (p_vld),
    .num_i    (p_num_sat),
    .den_i    (p_den_sat),
    .side_i   (p_bright),
    .vld_o    (),
    .quo_o    (ds_quo),
    .rem_nz_o (),
    .side_o   (ds_bright)
  );

  hsv_finish #(
    .CHANNEL_BITS      (CHANNEL_BITS),
    .HUE_FRACTION_BITS (HUE_FRACTION_BITS),
    .Q_W               (Q_W)
  ) u_finish (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (dh_vld),
    .q_hue_i  (dh_quo),
    .rem_nz_i (dh_rem_nz),
    .side_i   (dh_side),
    .q_sat_i  (ds_quo),
    .bright_i (ds_bright),
    .vld_o    (m_axis_tvalid),
    .hue_o    (o_hue),
    .sat_o    (o_sat),
    .bright_o (o_bright)
  );

  assign m_axis_tdata = OUT_W'({o_bright, o_sat, o_hue});

endmodule

FILE: src/hsv_checker.sv
// Port-level checks for the RGB to HSV converter, bound to the top level.
module hsv_checker #(
  parameter int unsigned CHANNEL_BITS      = hsv_pkg::CHANNEL_BITS_DEF,
  parameter int unsigned HUE_FRACTION_BITS = hsv_pkg::HUE_FRACTION_BITS_DEF
) (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [(($clog2(hsv_pkg::DEG_TURN*(2**HUE_FRACTION_BITS))+2*CHANNEL_BITS+7)/8)*8-1:0]
              m_axis_tdata
);
  import hsv_pkg::*;

  localparam int unsigned CB     = CHANNEL_BITS;
  localparam int unsigned DEG360 = DEG_TURN * (2 ** HUE_FRACTION_BITS);
  localparam int unsigned HUE_W  = $clog2(DEG360);

  logic [HUE_W-1:0] hue;
  logic [CB-1:0]    sat, bright;

  assign hue    = m_axis_tdata[0 +: HUE_W];
  assign sat    = m_axis_tdata[HUE_W +: CB];
  assign bright = m_axis_tdata[HUE_W+CB +: CB];

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // With no result pending, the converter must take a new pixel.
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with an empty output");

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ({1'b0, hue} < (HUE_W+1)'(DEG360)))
    else $error("hue out of range");

  // Grey pixels have no hue.
  a_grey_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (sat == '0) |-> (hue == '0))
    else $error("hue set on an unsaturated pixel");

  a_black_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (bright == '0) |-> (sat == '0))
    else $error("saturation set on a black pixel");

endmodule

bind rgb_to_hsv_converter hsv_checker #(
  .CHANNEL_BITS      (CHANNEL_BITS),
  .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
) u_hsv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
